// File: rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants of the positional circular list
// Sizes, operation and status codes, free-slot manager structs and helpers
// that fit request words into stored words and back.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic [1:0]            op_t;
  typedef logic [1:0]            status_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_READ   = 2'd2;
  localparam op_t OP_CLEAR  = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_POS = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  // commands to the free-slot manager
  typedef struct packed {
    logic  clear;  // forget every slot
    logic  pop;    // head of free chain taken, slot carries the next head
    logic  bump;   // next never-used slot taken
    logic  push;   // slot returned to the front of the free chain
    slot_t slot;
  } free_cmd_t;

  typedef struct packed {
    slot_t  head;    // front of the free chain
    logic   listed;  // free chain holds at least one slot
    slot_t  fresh;   // lowest slot never handed out since the last clear
    count_t len;     // slots on the free chain
    count_t used;    // never-used slots handed out since the last clear
  } free_stat_t;

  function automatic word_t to_word(input logic [VAL_W-1:0] v);
    word_t w;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      w[i] = (i < VAL_W) ? v[i % VAL_W] : 1'b0;
    end
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] from_word(input word_t w);
    logic [VAL_W-1:0] r;
    for (int i = 0; i < VAL_W; i++) begin
      r[i] = (i < DATA_WIDTH) ? w[i % DATA_WIDTH] : 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/pcl_ifs.sv
// ----------------------------------------------------------------------------
// pcl_ifs: request and response channels of the positional circular list
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pcl_req_if;
  import pcl_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);
endinterface

interface pcl_rsp_if;
  import pcl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  status_t                 status;
  logic [LEN_W-1:0]        length;
  modport source (output valid, result_value, status, length, input ready);
  modport sink (input valid, result_value, status, length, output ready);
endinterface

// File: rtl/positional_circular_list_top.sv
// ----------------------------------------------------------------------------
// positional_circular_list_top: ordered circular list with positional access
// Elements sit in slots of an element memory and are joined in a ring by a
// link memory; insert, delete and read walk the ring from the tail.
//
//   channel  role    payload
//   req      sink    op, position, value
//   rsp      source  result_value, status, length
//
// path from accept to the result register load: clear or a rejected request
// goes straight to S_FIN; read walks the ring (S_WALK), reads the element (S_GET);
// delete also unlinks it and returns its slot (S_FREE, or in S_GET for the last
// element); insert writes the element (S_INS), walks and links it in (S_WALK,
// S_LINK, both skipped for an empty list), after S_POP if the slot comes off the
// free chain; the walk reads one link per cycle; no memory clearing pass is needed
// a new item is taken while a result waits; it stalls before its result
// register load until the previous result is taken
// ----------------------------------------------------------------------------
module positional_circular_list_top (
  input logic      clk,
  input logic      rst,
  pcl_req_if.sink  req,
  pcl_rsp_if.source rsp
);
  import pcl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_GET  = 3'd5;
  localparam logic [2:0] S_FREE = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  word_t            val_r;
  status_t          st_r;
  logic [VAL_W-1:0] res_r;
  slot_t            s;
  count_t           k;
  slot_t            cur;
  slot_t            newslot;
  slot_t            tail;
  count_t           count;

  logic             out_valid;
  logic [VAL_W-1:0] out_value;
  status_t          out_status;
  logic [LEN_W-1:0] out_length;

  logic  link_we, link_re;
  slot_t link_waddr, link_raddr, link_wdata, link_rdata;
  logic  elem_we, elem_re;
  slot_t elem_waddr, elem_raddr;
  word_t elem_wdata, elem_rdata;

  free_cmd_t  fcmd;
  free_stat_t fstat;

  logic             accept;
  logic             out_free;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  status_t          req_status;
  logic             req_ins;

  pcl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  pcl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .re    (elem_re),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  pcl_free u_free (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fcmd),
    .stat (fstat)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.length       = out_length;

  assign pos_x = CMP_W'(req.position);
  assign cnt_x = CMP_W'(count);

  // request check against the current length
  always_comb begin
    req_status = ST_OK;
    unique case (req.op)
      OP_INSERT: begin
        if (count >= count_t'(CAPACITY)) begin
          req_status = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          req_status = ST_BAD_POS;
        end
      end
      OP_DELETE, OP_READ: begin
        if (count == '0) begin
          req_status = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          req_status = ST_BAD_POS;
        end
      end
      OP_CLEAR: begin
        req_status = ST_OK;
      end
    endcase
  end

  assign req_ins  = (req.op == OP_INSERT) && (req_status == ST_OK);

  // memory ports, free-slot commands and next state
  always_comb begin
    state_next = state;
    link_we    = 1'b0;
    link_waddr = newslot;
    link_wdata = newslot;
    link_re    = 1'b0;
    link_raddr = tail;
    elem_we    = 1'b0;
    elem_waddr = newslot;
    elem_wdata = val_r;
    elem_re    = 1'b0;
    elem_raddr = link_rdata;
    fcmd       = '0;
    fcmd.slot  = link_rdata;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_CLEAR) begin
            fcmd.clear = 1'b1;
            state_next = S_FIN;
          end else if (req_status != ST_OK) begin
            state_next = S_FIN;
          end else if (req_ins) begin
            if (fstat.listed) begin
              // fetch the link of the chain head to learn the next free slot
              link_re    = 1'b1;
              link_raddr = fstat.head;
              state_next = S_POP;
            end else begin
              fcmd.bump  = 1'b1;
              state_next = S_INS;
            end
          end else begin
            link_re    = 1'b1;
            link_raddr = tail;
            state_next = S_WALK;
          end
        end
      end
      S_POP: begin
        fcmd.pop   = 1'b1;
        fcmd.slot  = link_rdata;
        state_next = S_INS;
      end
      S_INS: begin
        elem_we = 1'b1;
        if (count == '0) begin
          // lone element links to itself
          link_we    = 1'b1;
          link_waddr = newslot;
          link_wdata = newslot;
          state_next = S_FIN;
        end else begin
          link_re    = 1'b1;
          link_raddr = tail;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        // link_rdata holds the successor of s
        if (k != '0) begin
          link_re    = 1'b1;
          link_raddr = link_rdata;
        end else if (op_r == OP_INSERT) begin
          link_we    = 1'b1;
          link_waddr = newslot;
          link_wdata = link_rdata;
          state_next = S_LINK;
        end else begin
          link_re    = 1'b1;
          link_raddr = link_rdata;
          elem_re    = 1'b1;
          elem_raddr = link_rdata;
          state_next = S_GET;
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = s;
        link_wdata = newslot;
        state_next = S_FIN;
      end
      S_GET: begin
        state_next = S_FIN;
        if (op_r == OP_DELETE) begin
          if (count == count_t'(1)) begin
            link_we    = 1'b1;
            link_waddr = cur;
            link_wdata = fstat.head;
            fcmd.push  = 1'b1;
            fcmd.slot  = cur;
          end else begin
            // unlink cur: predecessor now points past it
            link_we    = 1'b1;
            link_waddr = s;
            link_wdata = link_rdata;
            state_next = S_FREE;
          end
        end
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = fstat.head;
        fcmd.push  = 1'b1;
        fcmd.slot  = cur;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a fresh result may replace the one taken in the same cycle
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.op == OP_CLEAR) begin
            count <= '0;
            tail  <= '0;
          end
        end
        S_INS: begin
          if (count == '0) begin
            tail  <= newslot;
            count <= count + count_t'(1);
          end
        end
        S_LINK: begin
          if (CMP_W'(pos_r) == CMP_W'(count) + CMP_W'(1)) begin
            tail <= newslot;
          end
          count <= count + count_t'(1);
        end
        S_GET: begin
          if (op_r == OP_DELETE) begin
            if (count == count_t'(1)) begin
              tail  <= '0;
              count <= count - count_t'(1);
            end else if (cur == tail) begin
              tail <= s;
            end
          end
        end
        S_FREE: begin
          count <= count - count_t'(1);
        end
        S_POP, S_WALK, S_FIN: begin
        end
      endcase
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r    <= req.op;
          pos_r   <= req.position;
          val_r   <= to_word(req.value);
          st_r    <= req_status;
          res_r   <= '0;
          s       <= tail;
          k       <= count_t'(req.position) - count_t'(1);
          newslot <= fstat.listed ? fstat.head : fstat.fresh;
        end
      end
      S_WALK: begin
        if (k != '0) begin
          s <= link_rdata;
          k <= k - count_t'(1);
        end else begin
          cur <= link_rdata;
        end
      end
      S_GET: begin
        res_r <= from_word(elem_rdata);
      end
      S_FIN: begin
        if (out_free) begin
          out_value  <= res_r;
          out_status <= st_r;
          out_length <= LEN_W'(count);
        end
      end
      S_POP, S_INS, S_LINK, S_FREE: begin
      end
    endcase
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(CAPACITY))
    else $error("element count above capacity");

  a_slot_books: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fstat.used == count + fstat.len)
    else $error("slot bookkeeping out of step with element count");

  a_link_clash: assert property (@(posedge clk) disable iff (rst)
    !(link_we && link_re && link_waddr == link_raddr))
    else $error("link memory read and write hit the same slot");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> rsp.length == '0)
    else $error("empty status with nonzero length");

endmodule

// File: rtl/pcl_ram.sv
// ----------------------------------------------------------------------------
// pcl_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pcl_free.sv
// ----------------------------------------------------------------------------
// pcl_free: free-slot manager
// Hands out never-used slots by a fill count, and reuses returned slots
// through a free chain kept in the link memory. Clear resets both at once.
// ----------------------------------------------------------------------------
module pcl_free (
  input  logic                   clk,
  input  logic                   rst,
  input  pcl_pkg::free_cmd_t     cmd,
  output pcl_pkg::free_stat_t    stat
);
  import pcl_pkg::*;

  slot_t  head;
  count_t len;
  count_t used;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      len  <= '0;
      used <= '0;
    end else begin
      priority if (cmd.pop) begin
        len <= len - count_t'(1);
      end else if (cmd.bump) begin
        used <= used + count_t'(1);
      end else if (cmd.push) begin
        len <= len + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop || cmd.push) begin
      head <= cmd.slot;
    end
  end

  assign stat.head   = head;
  assign stat.listed = (len != '0);
  assign stat.fresh  = used[SLOT_W-1:0];
  assign stat.len    = len;
  assign stat.used   = used;

  a_pop_listed: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> len != '0)
    else $error("free chain popped while empty");

  a_bump_only_unlisted: assert property (@(posedge clk) disable iff (rst)
    cmd.bump |-> (len == '0) && (used < count_t'(CAPACITY)))
    else $error("fresh slot taken while chain holds slots or store is used up");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> len < count_t'(CAPACITY))
    else $error("free chain overflow");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the positional circular list
// Drives insert, delete, read and clear requests with random bursts and
// gaps, keeps an ordered copy of the list to predict every response and
// checks each response field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import pcl_pkg::*;

  localparam int RUN_LIMIT  = 400000;
  localparam int END_WAIT   = 2 * CAPACITY + 20;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               drain;  // hold this item back until all responses are in
  } req_item_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcl_req_if req ();
  pcl_rsp_if rsp ();

  positional_circular_list_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  req_item_t    req_items[$];
  list_result_t pending_results[$];
  word_t        list_words[$];
  int           gen_len;
  int           errors;

  // ordered copy of the list, updated for every accepted item
  task automatic list_apply(input req_item_t it);
    list_result_t r;
    int           n;
    int           p;
    word_t        w;
    n = list_words.size();
    p = it.pos;
    r.value  = '0;
    r.status = ST_OK;
    case (it.op)
      OP_INSERT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else if (p < 1 || p > n + 1) r.status = ST_BAD_POS;
        else list_words.insert(p - 1, word_t'(it.val));
      end
      OP_DELETE, OP_READ: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > n) r.status = ST_BAD_POS;
        else begin
          w = list_words[p - 1];
          r.value = VAL_W'(w);
          if (it.op == OP_DELETE) list_words.delete(p - 1);
        end
      end
      default: list_words.delete();
    endcase
    r.length = LEN_W'(list_words.size());
    pending_results.push_back(r);
  endtask

  // queue a request and track the list length it leads to
  task automatic add_item(input op_t op, input int pos, input logic [VAL_W-1:0] val);
    req_item_t it;
    it.op    = op;
    it.pos   = POS_W'(pos);
    it.val   = val;
    it.drain = 1'b0;
    req_items.push_back(it);
    case (op)
      OP_INSERT: if (gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1) gen_len++;
      OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  // legal position, leaning toward the front and the end
  function automatic int pick_pos(input int hi);
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) return 1;
    if (k == 1) return hi;
    return $urandom_range(1, hi);
  endfunction

  function automatic logic [VAL_W-1:0] pick_val();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 32'h8000_0000;
    if (k == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic legal_op(input op_t op);
    if (op == OP_INSERT) add_item(op, pick_pos(gen_len + 1), pick_val());
    else if (gen_len == 0) add_item(op, 1, 0);
    else add_item(op, pick_pos(gen_len), 0);
  endtask

  task automatic gen_directed();
    add_item(OP_READ, 1, 0);               // empty list
    add_item(OP_DELETE, 1, 0);
    add_item(OP_READ, 0, 0);
    add_item(OP_INSERT, 0, 32'h1234_5678); // bad position
    add_item(OP_INSERT, 2, 32'h1234_5678);
    add_item(OP_INSERT, 1, 32'h7fff_ffff);
    add_item(OP_INSERT, 2, 32'h8000_0000); // end
    add_item(OP_INSERT, 1, 32'hffff_ffff); // front
    add_item(OP_INSERT, 2, 32'h0000_0000); // middle
    add_item(OP_INSERT, 127, 32'h1);
    add_item(OP_READ, 0, 0);
    add_item(OP_READ, 5, 0);
    add_item(OP_READ, 4, 0);
    add_item(OP_READ, 1, 0);
    add_item(OP_DELETE, 127, 0);
    add_item(OP_DELETE, 4, 0);             // tail goes, predecessor becomes tail
    add_item(OP_INSERT, 4, 32'h5555_5555);
    add_item(OP_DELETE, 1, 0);             // head
    add_item(OP_READ, 2, 0);
    add_item(OP_CLEAR, 0, 0);
    add_item(OP_CLEAR, 127, 32'hffff_ffff);
    add_item(OP_INSERT, 1, 32'haaaa_aaaa);
    add_item(OP_DELETE, 1, 0);             // last element empties the list
    add_item(OP_INSERT, 1, pick_val());
  endtask

  task automatic gen_random(input int target);
    int n_rand;
    int kind;
    int span;
    int r;
    n_rand = 0;
    // fill up, then hit the full list
    while (gen_len < CAPACITY) begin
      legal_op(OP_INSERT);
      n_rand++;
    end
    repeat (3) begin
      add_item(OP_INSERT, $urandom_range(0, 127), pick_val());
      n_rand++;
    end
    add_item(OP_READ, CAPACITY, 0);
    add_item(OP_DELETE, CAPACITY, 0);
    n_rand += 2;
    while (n_rand < target) begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          add_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
        end else begin
          r = $urandom_range(0, 99);
          case (kind)
            0: legal_op(r < 75 ? OP_INSERT : (r < 90 ? OP_READ : OP_DELETE));
            1: legal_op(r < 70 ? OP_DELETE : (r < 85 ? OP_INSERT : OP_READ));
            2: begin
              if (r == 0) add_item(OP_CLEAR, 0, 0);
              else legal_op(r < 40 ? OP_INSERT : (r < 75 ? OP_DELETE : OP_READ));
            end
            default: legal_op(r < 60 ? OP_READ : (r < 85 ? OP_INSERT : OP_DELETE));
          endcase
        end
        n_rand++;
      end
    end
  endtask

  // request driver
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      req.valid  <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      nv = req.valid;
      if (req.valid && req.ready) begin
        list_apply(req_items.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_items.size() > 0 &&
                     (!req_items[0].drain || pending_results.size() == 0)) begin
          nv = 1'b1;
          req.op       <= req_items[0].op;
          req.position <= req_items[0].pos;
          req.value    <= req_items[0].val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      req.valid <= nv;
    end
  end

  // response monitor and checker
  int results_seen;
  int hold_left;
  int stall_phase;
  bit hold_done;

  always @(posedge clk) begin
    list_result_t e;
    logic         nr;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: value %0d status %0d length %0d",
                     rsp.result_value, rsp.status, rsp.length);
        end else begin
          e = pending_results.pop_front();
          if (rsp.result_value !== e.value || rsp.status !== e.status ||
              rsp.length !== e.length) begin
            errors++;
            // fields in order value, status, length
            if (errors <= 10)
              $display("response %0d wrong: expected %0d %0d %0d, got %0d %0d %0d",
                       results_seen, $signed(e.value), e.status, e.length,
                       rsp.result_value, rsp.status, rsp.length);
          end
        end
      end
      stall_phase++;
      // one long hold-off so the block backs up into the request side
      if (!hold_done && results_seen >= 350) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else begin
        case ((stall_phase / 96) % 4)
          0: nr = 1'b1;
          1: nr = 1'($urandom_range(0, 1));
          2: nr = ($urandom_range(0, 3) == 0);
          default: nr = (stall_phase % 7) != 0;
        endcase
      end
      rsp.ready <= nr;
    end
  end

  int cycles;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req.valid    = 1'b0;
    req.op       = OP_INSERT;
    req.position = '0;
    req.value    = '0;
    rsp.ready    = 1'b0;
    gen_len      = 0;
    gen_directed();
    gen_random(RAND_ITEMS);
    // sender waits for a fully drained block at these two points
    req_items[req_items.size() / 3].drain       = 1'b1;
    req_items[(2 * req_items.size()) / 3].drain = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (req_items.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pcl_pkg.sv
rtl/pcl_ifs.sv
rtl/pcl_ram.sv
rtl/pcl_free.sv
rtl/positional_circular_list_top.sv
sim/tb.sv
